// File: sv/sc2a_pkg.sv
`timescale 1ns / 1ps
// Shared types, scan codes and lookup tables for the scan code to ASCII translator.
// No dependencies; used by the stream interface instances and the top level.
package sc2a_pkg;

	// Input beat: one keyboard controller byte and its port flag
	typedef struct packed {
		logic [7:0] scan_byte;
		logic       from_mouse;
	} in_beat_t;

	// Output beat: one translated character
	typedef struct packed {
		logic [6:0] ascii_char;
	} out_beat_t;

	// Scan code set 1 codes with a side effect on the key flags
	localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] CODE_CAPS_MAKE    = 8'h3a;
	localparam logic [7:0] CODE_LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hb6;

	// Lower/upper case differ in this bit
	localparam logic [6:0] CASE_BIT = 7'h20;
	localparam logic [6:0] CHAR_LOW_A = 7'h61;
	localparam logic [6:0] CHAR_LOW_Z = 7'h7a;
	localparam logic [6:0] CHAR_NONE = 7'h00;

	// Codes below this value are mapped by the tables
	localparam int TABLE_SIZE = 58;
	localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

	// Unshifted US layout; zero marks an unmapped code
	localparam logic [6:0] PLAIN_MAP [TABLE_SIZE] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b,
		7'h6c, 7'h3b, 7'h27, 7'h60, 7'h00, 7'h5c,
		7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, 7'h6d, 7'h2c,
		7'h2e, 7'h2f, 7'h00, 7'h00, 7'h00, 7'h20
	};

	// Shifted US layout
	localparam logic [6:0] SHIFT_MAP [TABLE_SIZE] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b,
		7'h4c, 7'h3a, 7'h22, 7'h7e, 7'h00, 7'h7c,
		7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e, 7'h4d, 7'h3c,
		7'h3e, 7'h3f, 7'h00, 7'h00, 7'h00, 7'h20
	};

endpackage

// File: sv/sc2a_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat.
// The payload type is set per instance, normally a struct from sc2a_pkg.
interface sc2a_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/scan_code_to_ascii_translator.sv
`timescale 1ns / 1ps
// Top level: scan code set 1 to US ASCII translator with shift and caps lock tracking.
// Depends on sc2a_pkg (types, codes, tables) and sc2a_stream_if (channels).

// The block takes one keyboard byte per cycle on the scan channel and can keep
// that rate indefinitely while the chars channel keeps up. A beat is registered,
// then looked up in the layout tables against the current shift and caps lock
// flags and written to the output register, from which its character is offered
// on chars. Shift and caps lock bytes, break codes, unmapped codes, 0xE0
// prefixes and mouse bytes give no character.
// When chars stalls, the output register and the input register each hold one
// beat, after which scan ready drops until chars takes its beat.
module scan_code_to_ascii_translator (
	input logic clk,
	input logic arst_n,
	sc2a_stream_if.sink   scan,
	sc2a_stream_if.source chars
);

	// Input stage
	logic               valid_s1;
	sc2a_pkg::in_beat_t beat_s1;

	// Result stage
	logic                valid_s2;
	sc2a_pkg::out_beat_t beat_s2;

	// Key flags
	logic lshift_q;
	logic rshift_q;
	logic caps_q;

	logic                             advance;
	logic                             live;
	logic                             in_table;
	logic [sc2a_pkg::TABLE_IDX_W-1:0] idx;
	logic [6:0]                       plain_ch;
	logic [6:0]                       shift_ch;
	logic [6:0]                       ch;
	logic                             shift;
	logic                             is_letter;
	logic                             is_flag_code;
	logic                             emit;

	// Stage 1 moves on when the result register is free or being emptied
	assign advance = !valid_s2 || chars.ready;
	assign scan.ready = !valid_s1 || advance;
	assign live = valid_s1 && advance && !beat_s1.from_mouse;

	// Translate the stage 1 byte
	always_comb begin
		in_table = beat_s1.scan_byte < 8'(sc2a_pkg::TABLE_SIZE);
		idx = beat_s1.scan_byte[sc2a_pkg::TABLE_IDX_W-1:0];
		plain_ch = in_table ? sc2a_pkg::PLAIN_MAP[idx] : sc2a_pkg::CHAR_NONE;
		shift_ch = in_table ? sc2a_pkg::SHIFT_MAP[idx] : sc2a_pkg::CHAR_NONE;
		shift = lshift_q || rshift_q;
		is_letter = plain_ch >= sc2a_pkg::CHAR_LOW_A && plain_ch <= sc2a_pkg::CHAR_LOW_Z;
		is_flag_code = beat_s1.scan_byte == sc2a_pkg::CODE_LSHIFT_MAKE
			|| beat_s1.scan_byte == sc2a_pkg::CODE_RSHIFT_MAKE
			|| beat_s1.scan_byte == sc2a_pkg::CODE_CAPS_MAKE;
		if (is_letter) begin
			ch = (shift || caps_q) ? (plain_ch & ~sc2a_pkg::CASE_BIT) : plain_ch;
		end else begin
			ch = shift ? shift_ch : plain_ch;
		end
		emit = !is_flag_code && plain_ch != sc2a_pkg::CHAR_NONE;
	end

	// Capture an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			beat_s1 <= scan.data;
		end
	end

	// Update shift and caps flags as each keyboard byte passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			caps_q <= 1'b0;
		end else if (live) begin
			case (beat_s1.scan_byte)
				sc2a_pkg::CODE_LSHIFT_MAKE: begin
					lshift_q <= 1'b1;
				end
				sc2a_pkg::CODE_RSHIFT_MAKE: begin
					rshift_q <= 1'b1;
				end
				sc2a_pkg::CODE_LSHIFT_BREAK: begin
					lshift_q <= 1'b0;
				end
				sc2a_pkg::CODE_RSHIFT_BREAK: begin
					rshift_q <= 1'b0;
				end
				sc2a_pkg::CODE_CAPS_MAKE: begin
					caps_q <= !caps_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= live && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (live && emit) begin
			beat_s2.ascii_char <= ch;
		end
	end

	assign chars.valid = valid_s2;
	assign chars.data = beat_s2;

`ifndef SYNTHESIS
	// A delivered character is never the unmapped marker
	a_no_null_char: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid |-> chars.data.ascii_char != sc2a_pkg::CHAR_NONE)
		else $error("null character delivered");

	// Mouse bytes leave the key flags alone
	a_mouse_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && beat_s1.from_mouse)
		|=> $stable(lshift_q) && $stable(rshift_q) && $stable(caps_q))
		else $error("mouse byte changed key flags");

	// Caps make toggles caps lock
	a_caps_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(live && beat_s1.scan_byte == sc2a_pkg::CODE_CAPS_MAKE)
		|=> caps_q != $past(caps_q))
		else $error("caps lock did not toggle");

	// With the result register empty the block always takes a byte
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> scan.ready)
		else $error("stalled input with empty output");
`endif

endmodule
